// ----- src/hpt_pkg.sv -----
// shared constants and types for the homogeneous point transform
// no dependencies; imported by the interfaces, the divider lane, the top level and the testbench
`timescale 1ns / 1ps

package hpt_pkg;

	// coordinate and matrix element width, signed q16.16
	localparam int CW = 32;
	// configuration register width and count
	localparam int RW = 64;
	localparam int NREG = 8;
	localparam int IDXW = 4;
	localparam int RSELW = $clog2(NREG);
	// one 32x32 product and the exact q34.32 column sum
	localparam int PW = 2 * CW;
	localparam int SW = PW + 2;
	// column sum rounded down to q34.16
	localparam int TW = SW - 16;
	// quotient bits, one per divider stage
	localparam int QB = 32;
	// divider partial remainder and compare widths
	localparam int NW = TW + 16;
	localparam int CMPW = TW + QB;

	// matrix is the identity after reset
	localparam logic [RW-1:0] REG_RST [NREG] = '{
		64'h0000_0000_0001_0000, 64'h0,
		64'h0001_0000_0000_0000, 64'h0,
		64'h0, 64'h0000_0000_0001_0000,
		64'h0, 64'h0001_0000_0000_0000
	};

	// saturation limits of the quotient magnitude
	localparam logic [QB-1:0] LIM_POS = 32'h7FFF_FFFF;
	localparam logic [QB-1:0] LIM_NEG = 32'h8000_0000;

	// per-item control traveling beside the divider lanes
	typedef struct packed {
		logic valid;
		logic w_zero;
	} side_t;

endpackage

// ----- src/hpt_if.sv -----
// valid/ready channels for input points and transformed results
// depends on hpt_pkg for the field widths
`timescale 1ns / 1ps

interface hpt_pt_if;
	import hpt_pkg::*;
	logic valid;
	logic ready;
	logic signed [CW-1:0] in_x;
	logic signed [CW-1:0] in_y;
	logic signed [CW-1:0] in_z;
	modport source (output valid, output in_x, output in_y, output in_z, input ready);
	modport sink (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface hpt_res_if;
	import hpt_pkg::*;
	logic valid;
	logic ready;
	logic signed [CW-1:0] out_x;
	logic signed [CW-1:0] out_y;
	logic signed [CW-1:0] out_z;
	logic w_zero;
	logic saturated;
	modport source (output valid, output out_x, output out_y, output out_z,
		output w_zero, output saturated, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z,
		input w_zero, input saturated, output ready);
endinterface

// ----- src/hpt_div_lane.sv -----
// pipelined signed q16.16 divider lane, one quotient bit per stage
// depends on hpt_pkg; its stages advance only while en is high
`timescale 1ns / 1ps

module hpt_div_lane (
	input  logic clk,
	input  logic en,
	input  logic signed [hpt_pkg::TW-1:0] num,
	input  logic signed [hpt_pkg::TW-1:0] den,
	output logic [hpt_pkg::CW-1:0] res,
	output logic clip
);
	import hpt_pkg::*;

	typedef struct packed {
		logic neg;
		logic ovf;
	} lane_ctl_t;

	logic [NW-1:0] rem_s [QB+1];
	logic [TW-1:0] md_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	lane_ctl_t ctl_s [QB+1];

	logic [TW-1:0] mn;
	logic [TW-1:0] md;
	logic [QB-1:0] lim;
	logic [QB-1:0] qv;
	logic qclip;

	// magnitudes and the early overflow check (quotient of 2^32 or more)
	always_comb begin
		mn = num[TW-1] ? TW'(-num) : TW'(num);
		md = den[TW-1] ? TW'(-den) : TW'(den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {mn, 16'b0};
			md_s[0] <= md;
			quo_s[0] <= '0;
			ctl_s[0].neg <= num[TW-1] ^ den[TW-1];
			ctl_s[0].ovf <= {16'b0, mn} >= {md, 16'b0};
		end
	end

	// restoring division, bit QB-1-d decided in stage d
	for (genvar d = 0; d < QB; d++) begin : g_stage
		logic [CMPW-1:0] shd;
		logic [CMPW-1:0] rw;
		logic ge;
		always_comb begin
			shd = {{QB{1'b0}}, md_s[d]} << (QB - 1 - d);
			rw = {{(CMPW-NW){1'b0}}, rem_s[d]};
			ge = rw >= shd;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[d+1] <= ge ? NW'(rw - shd) : rem_s[d];
				md_s[d+1] <= md_s[d];
				quo_s[d+1] <= {quo_s[d][QB-2:0], ge};
				ctl_s[d+1] <= ctl_s[d];
			end
		end
	end

	// saturate to the signed range and restore the sign
	always_comb begin
		lim = ctl_s[QB].neg ? LIM_NEG : LIM_POS;
		qclip = ctl_s[QB].ovf || (quo_s[QB] > lim);
		qv = qclip ? lim : quo_s[QB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= ctl_s[QB].neg ? CW'(-qv) : qv;
			clip <= qclip;
		end
	end

endmodule

// ----- src/homogeneous_point_transform_top.sv -----
// Transforms a q16.16 point (x,y,z,1) by a 4x4 matrix and divides by w. One point is
// accepted per clock while the result side takes results. Each point passes three
// stages for the twelve multiplies and the column sums, then a divider lane per
// coordinate that resolves one quotient bit per stage over 32 stages, plus a load and
// an output stage. A stalled result holds the whole pipeline. The user writes the matrix
// registers through the cfg port only while idle; the block does not enforce this.
// depends on hpt_pkg, hpt_if.sv and hpt_div_lane
`timescale 1ns / 1ps

module homogeneous_point_transform_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [hpt_pkg::IDXW-1:0] cfg_index,
	input  logic [hpt_pkg::RW-1:0] cfg_data,
	hpt_pt_if.sink pt,
	hpt_res_if.source res
);
	import hpt_pkg::*;

	localparam int SIDE_N = QB + 2;

	logic [RW-1:0] regs_q [NREG];
	logic signed [CW-1:0] m [4][4];
	logic signed [CW-1:0] vin [3];

	logic signed [PW-1:0] prod_s1 [3][4];
	logic signed [SW-1:0] wconst_s1 [4];
	logic signed [SW-1:0] suma_s2 [4];
	logic signed [SW-1:0] sumb_s2 [4];
	logic signed [TW-1:0] t_s3 [4];
	logic v_s1, v_s2, v_s3;
	side_t side_s [SIDE_N];

	logic signed [SW-1:0] tsum [4];
	logic en;
	logic [CW-1:0] lane_res [3];
	logic lane_clip [3];

	// global advance: move unless a finished result is held
	assign en = !side_s[SIDE_N-1].valid || res.ready;
	assign pt.ready = en;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) regs_q[i] <= REG_RST[i];
		end else if (cfg_we && (cfg_index < IDXW'(NREG))) begin
			regs_q[cfg_index[RSELW-1:0]] <= cfg_data;
		end
	end

	// element unpacking: row r holds two registers, low half is the even column
	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			assign m[r][c] = regs_q[2*r + c/2][(c%2)*CW +: CW];
		end
	end

	assign vin[0] = pt.in_x;
	assign vin[1] = pt.in_y;
	assign vin[2] = pt.in_z;

	// stage 1: products and the w row scaled by one
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				for (int j = 0; j < 3; j++) prod_s1[j][c] <= vin[j] * m[j][c];
				wconst_s1[c] <= SW'(signed'({m[3][c], 16'b0}));
			end
		end
	end

	// stage 2: pair sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				suma_s2[c] <= SW'(prod_s1[0][c]) + SW'(prod_s1[1][c]);
				sumb_s2[c] <= SW'(prod_s1[2][c]) + wconst_s1[c];
			end
		end
	end

	// stage 3: exact column sum, rounded down to q34.16
	always_comb begin
		for (int c = 0; c < 4; c++) tsum[c] = suma_s2[c] + sumb_s2[c];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) t_s3[c] <= tsum[c][SW-1:16];
		end
	end

	// valid and w flag beside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int i = 0; i < SIDE_N; i++) side_s[i] <= '0;
		end else if (en) begin
			v_s1 <= pt.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			side_s[0].valid <= v_s3;
			side_s[0].w_zero <= t_s3[3] == '0;
			for (int i = 1; i < SIDE_N; i++) side_s[i] <= side_s[i-1];
		end
	end

	// one divider lane per coordinate
	for (genvar c = 0; c < 3; c++) begin : g_lane
		hpt_div_lane u_lane (
			.clk (clk),
			.en  (en),
			.num (t_s3[c]),
			.den (t_s3[3]),
			.res (lane_res[c]),
			.clip(lane_clip[c])
		);
	end

	// result, forced to zero when w was zero
	always_comb begin
		res.valid = side_s[SIDE_N-1].valid;
		res.w_zero = side_s[SIDE_N-1].w_zero;
		res.out_x = res.w_zero ? '0 : lane_res[0];
		res.out_y = res.w_zero ? '0 : lane_res[1];
		res.out_z = res.w_zero ? '0 : lane_res[2];
		res.saturated = !res.w_zero && (lane_clip[0] || lane_clip[1] || lane_clip[2]);
	end

	// zero w gives zero coordinates
	a_wzero_outs: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.w_zero |-> res.out_x == '0 && res.out_y == '0 && res.out_z == '0)
		else $error("w_zero result with nonzero coordinates");

	// the two flags never appear together
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.w_zero && res.saturated))
		else $error("w_zero and saturated both set");

	// a clipped result sits at a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.saturated |->
			res.out_x == 32'sh7FFF_FFFF || res.out_x == 32'sh8000_0000 ||
			res.out_y == 32'sh7FFF_FFFF || res.out_y == 32'sh8000_0000 ||
			res.out_z == 32'sh7FFF_FFFF || res.out_z == 32'sh8000_0000)
		else $error("saturated result not at a limit");

	// a stall freezes the tail of the pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(side_s[SIDE_N-1]) && $stable(lane_res[0]))
		else $error("pipeline moved during stall");

endmodule

// ----- verif/homogeneous_point_transform_top_tb.sv -----
// self-checking testbench for the homogeneous point transform top level
// depends on hpt_pkg, hpt_if.sv and the rtl under src
`timescale 1ns / 1ps

module homogeneous_point_transform_top_tb;
	import hpt_pkg::*;

	// register indexes of the matrix write port
	localparam logic [IDXW-1:0] IDX_ROW0_A = 4'd0;
	localparam logic [IDXW-1:0] IDX_ROW0_B = 4'd1;
	localparam logic [IDXW-1:0] IDX_ROW1_A = 4'd2;
	localparam logic [IDXW-1:0] IDX_ROW1_B = 4'd3;
	localparam logic [IDXW-1:0] IDX_ROW2_A = 4'd4;
	localparam logic [IDXW-1:0] IDX_ROW2_B = 4'd5;
	localparam logic [IDXW-1:0] IDX_ROW3_A = 4'd6;
	localparam logic [IDXW-1:0] IDX_ROW3_B = 4'd7;
	localparam logic [IDXW-1:0] IDX_UNUSED = 4'd9;

	localparam logic [CW-1:0] Q_ONE = 32'h0001_0000;
	localparam logic [CW-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [CW-1:0] Q_MIN = 32'h8000_0000;
	// pipeline depth plus margin, waited out before matrix writes and at the end
	localparam int DRAIN_CYCLES = 50;

	typedef enum int {
		MX_IDENT, MX_PERSP, MX_TINYW, MX_ZEROW,
		MX_RANDOM, MX_SMALL, MX_MAXPOS, MX_MAXNEG
	} matrix_kind_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic w_zero;
		logic saturated;
	} proj_t;

	typedef struct {
		matrix_kind_t mx;
		logic [CW-1:0] x, y, z;
		bit typed;
		proj_t want;
	} vec_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDXW-1:0] cfg_index;
	logic [RW-1:0] cfg_data;

	hpt_pt_if pt ();
	hpt_res_if res ();

	homogeneous_point_transform_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pt(pt.sink), .res(res.source)
	);

	logic [RW-1:0] matrix_regs [NREG];
	proj_t proj_q [$];
	int err_cnt = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// matrix element as a wide signed value
	function automatic logic signed [79:0] elem(int row, int col);
		logic [RW-1:0] r;
		logic signed [CW-1:0] half;
		r = matrix_regs[2 * row + col / 2];
		half = (col % 2) ? r[63:32] : r[31:0];
		return 80'(half);
	endfunction

	// q16.16 quotient, truncated toward zero and clipped to 32 bits
	function automatic logic [CW-1:0] div_q16(logic signed [79:0] num,
			logic signed [79:0] den, inout logic clip);
		logic [79:0] mn, md, qi;
		logic [99:0] wide_q;
		logic [CW-1:0] lim;
		logic neg;
		neg = num[79] ^ den[79];
		mn = num[79] ? -num : num;
		md = den[79] ? -den : den;
		lim = neg ? Q_MIN : Q_MAX;
		qi = mn / md;
		if (qi >= 80'h10000) begin
			wide_q = 100'(lim);
			clip = 1'b1;
		end else begin
			wide_q = (100'(mn) << 16) / 100'(md);
			if (wide_q > 100'(lim)) begin
				wide_q = 100'(lim);
				clip = 1'b1;
			end
		end
		return neg ? -wide_q[CW-1:0] : wide_q[CW-1:0];
	endfunction

	// row vector (x,y,z,1) times the matrix, then divide by w
	function automatic proj_t project(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		logic signed [79:0] v [4];
		logic signed [79:0] t [4];
		logic signed [79:0] acc;
		logic clip;
		proj_t p;
		v[0] = 80'(signed'(x));
		v[1] = 80'(signed'(y));
		v[2] = 80'(signed'(z));
		v[3] = 80'(signed'(Q_ONE));
		for (int c = 0; c < 4; c++) begin
			acc = '0;
			for (int j = 0; j < 4; j++)
				acc += v[j] * elem(j, c);
			t[c] = acc >>> 16;
		end
		p = '0;
		if (t[3] == 0) begin
			p.w_zero = 1'b1;
			return p;
		end
		clip = 1'b0;
		p.x = div_q16(t[0], t[3], clip);
		p.y = div_q16(t[1], t[3], clip);
		p.z = div_q16(t[2], t[3], clip);
		p.saturated = clip;
		return p;
	endfunction

	// one register write at a falling edge
	task automatic write_reg(logic [IDXW-1:0] idx, logic [RW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < NREG)
			matrix_regs[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CW-1:0] rand_elem(matrix_kind_t k);
		case (k)
			MX_SMALL: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
			MX_MAXPOS: return Q_MAX;
			MX_MAXNEG: return Q_MIN;
			default: return $urandom;
		endcase
	endfunction

	// wait for the pipeline to empty, then load a new matrix
	task automatic load_matrix(matrix_kind_t k);
		logic [RW-1:0] m [NREG];
		wait (proj_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		m = REG_RST;
		case (k)
			MX_PERSP: begin
				m[IDX_ROW2_B] = {Q_ONE, Q_ONE};
				m[IDX_ROW3_B] = '0;
			end
			MX_TINYW: begin
				m[IDX_ROW2_B] = {32'h0000_0001, Q_ONE};
				m[IDX_ROW3_B] = '0;
			end
			MX_ZEROW: begin
				for (int i = 0; i < NREG; i++)
					m[i] = {32'h0, rand_elem(MX_RANDOM)};
				m[IDX_ROW1_B] = '0;
				m[IDX_ROW3_B] = {32'h0, Q_ONE};
			end
			MX_RANDOM, MX_SMALL, MX_MAXPOS, MX_MAXNEG: begin
				for (int i = 0; i < NREG; i++)
					m[i] = {rand_elem(k), rand_elem(k)};
			end
			default: ;
		endcase
		// zero w column: every element of column 3 cleared
		if (k == MX_ZEROW) begin
			m[IDX_ROW0_B][63:32] = '0;
			m[IDX_ROW2_B][63:32] = '0;
		end
		for (int i = 0; i < NREG; i++)
			write_reg(i[IDXW-1:0], m[i]);
		// writes to an unused index must leave the matrix alone
		write_reg(IDX_UNUSED, {$urandom, $urandom});
	endtask

	// present one point until it transfers
	task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
			bit typed, proj_t want);
		bit done;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			if ($urandom_range(0, 99) < idle_pct) begin
				pt.valid <= 1'b0;
			end else begin
				pt.valid <= 1'b1;
				pt.in_x <= x;
				pt.in_y <= y;
				pt.in_z <= z;
			end
			@(posedge clk);
			if (pt.valid && pt.ready) begin
				done = 1'b1;
				proj_q.push_back(typed ? want : project(x, y, z));
			end
		end
	endtask

	function automatic logic [CW-1:0] rand_coord();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return $urandom;
		if (sel < 8)
			return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
		case ($urandom_range(0, 4))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return Q_ONE;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// result side ready, with random stalls
	always @(negedge clk)
		res.ready <= ($urandom_range(0, 99) >= stall_pct);

	// compare every result transfer with the oldest projection
	always @(posedge clk) begin
		proj_t want;
		if (arst_n && res.valid && res.ready) begin
			if (proj_q.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h", $time,
					res.out_x, res.out_y, res.out_z);
				err_cnt++;
			end else begin
				want = proj_q.pop_front();
				if (res.out_x !== want.x) begin
					$display("%0t: out_x expected %h got %h", $time, want.x, res.out_x);
					err_cnt++;
				end
				if (res.out_y !== want.y) begin
					$display("%0t: out_y expected %h got %h", $time, want.y, res.out_y);
					err_cnt++;
				end
				if (res.out_z !== want.z) begin
					$display("%0t: out_z expected %h got %h", $time, want.z, res.out_z);
					err_cnt++;
				end
				if (res.w_zero !== want.w_zero) begin
					$display("%0t: w_zero expected %b got %b", $time, want.w_zero,
						res.w_zero);
					err_cnt++;
				end
				if (res.saturated !== want.saturated) begin
					$display("%0t: saturated expected %b got %b", $time, want.saturated,
						res.saturated);
					err_cnt++;
				end
			end
		end
	end

	// stimulus
	initial begin
		vec_row_t rows [$];
		matrix_kind_t cur_mx;
		matrix_kind_t kinds [8];
		logic [CW-1:0] x, y, z;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pt.valid = 1'b0;
		pt.in_x = '0;
		pt.in_y = '0;
		pt.in_z = '0;
		res.ready = 1'b0;
		matrix_regs = REG_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// identity after reset: points pass through unchanged
		rows.push_back('{MX_IDENT, 0, 0, 0, 1, '{0, 0, 0, 0, 0}});
		rows.push_back('{MX_IDENT, Q_MAX, Q_MAX, Q_MAX, 1, '{Q_MAX, Q_MAX, Q_MAX, 0, 0}});
		rows.push_back('{MX_IDENT, Q_MIN, Q_MIN, Q_MIN, 1, '{Q_MIN, Q_MIN, Q_MIN, 0, 0}});
		rows.push_back('{MX_IDENT, Q_ONE, 32'hFFFF_0000, 32'h1234_5678, 1,
			'{Q_ONE, 32'hFFFF_0000, 32'h1234_5678, 0, 0}});
		rows.push_back('{MX_IDENT, 32'hFFFF_FFFF, 1, Q_MAX, 1,
			'{32'hFFFF_FFFF, 1, Q_MAX, 0, 0}});
		// w equals z: zero z gives the zero w flag
		rows.push_back('{MX_PERSP, Q_MAX, Q_MIN, 0, 1, '{0, 0, 0, 1, 0}});
		rows.push_back('{MX_PERSP, Q_MAX, Q_MIN, 1, 0, '0});
		rows.push_back('{MX_PERSP, Q_MIN, Q_MAX, 32'hFFFF_FFFF, 0, '0});
		rows.push_back('{MX_PERSP, 32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000, 0, '0});
		rows.push_back('{MX_PERSP, Q_MIN, Q_MIN, Q_MIN, 0, '0});
		rows.push_back('{MX_PERSP, Q_MAX, Q_MAX, Q_ONE, 0, '0});
		// w below one lsb after rounding down counts as zero
		rows.push_back('{MX_TINYW, Q_ONE, Q_ONE, 32'h0000_8000, 1, '{0, 0, 0, 1, 0}});
		rows.push_back('{MX_TINYW, Q_ONE, Q_ONE, 32'hFFFF_8000, 0, '0});
		rows.push_back('{MX_TINYW, 5, 7, Q_MAX, 0, '0});
		rows.push_back('{MX_MAXPOS, Q_MAX, Q_MAX, Q_MAX, 0, '0});
		rows.push_back('{MX_MAXNEG, Q_MIN, Q_MAX, Q_MIN, 0, '0});
		rows.push_back('{MX_MAXNEG, 0, 0, 0, 0, '0});

		cur_mx = MX_IDENT;
		foreach (rows[i]) begin
			if (rows[i].mx != cur_mx) begin
				cur_mx = rows[i].mx;
				@(negedge clk);
				pt.valid <= 1'b0;
				load_matrix(cur_mx);
			end
			send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
		end

		// random points under a sequence of matrices with idling and stalling phases
		kinds = '{MX_SMALL, MX_RANDOM, MX_PERSP, MX_ZEROW,
			MX_SMALL, MX_MAXPOS, MX_IDENT, MX_MAXNEG};
		for (int seg = 0; seg < 8; seg++) begin
			@(negedge clk);
			pt.valid <= 1'b0;
			load_matrix(kinds[seg]);
			case (seg % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 72; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 72; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			for (int n = 0; n < 86; n++) begin
				x = rand_coord();
				y = rand_coord();
				z = rand_coord();
				send_point(x, y, z, 1'b0, '0);
			end
		end
		@(negedge clk);
		pt.valid <= 1'b0;

		wait (proj_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- homogeneous_point_transform_top.f -----
src/hpt_pkg.sv
src/hpt_if.sv
src/hpt_div_lane.sv
src/homogeneous_point_transform_top.sv
verif/homogeneous_point_transform_top_tb.sv
